// ----- rtl/core/dtq_pkg.sv -----
`default_nettype none

package dtq_pkg;

    localparam int unsigned LEN_W      = 11;
    localparam int unsigned CDESC_W    = 32;
    localparam int unsigned DCNT_W     = 32;
    localparam logic [LEN_W-1:0] CAP_RESET = 11'd1000;

    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_PULL = 1'b1
    } t_kind;

    typedef struct packed {
        logic               kind;
        logic [CDESC_W-1:0] descriptor_in;
    } t_in_item;

    typedef struct packed {
        logic [CDESC_W-1:0] descriptor_out;
        logic               pulled_valid;
        logic               dropped;
        logic [LEN_W-1:0]   length;
        logic [LEN_W-1:0]   high_water;
        logic [DCNT_W-1:0]  drop_count;
    } t_out_item;

    // Status of one request after the queue state was updated.
    typedef struct packed {
        logic               pulled_valid;
        logic               dropped;
        logic [LEN_W-1:0]   length;
        logic [LEN_W-1:0]   high_water;
        logic [DCNT_W-1:0]  drop_count;
    } t_meta;

endpackage

`default_nettype wire

// ----- rtl/core/dtq_ram.sv -----
`default_nettype none

module dtq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/dtq_ctrl.sv -----
`default_nettype none

module dtq_ctrl #(
    parameter int unsigned DEPTH      = 1024,
    parameter int unsigned DESC_WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire dtq_pkg::t_in_item        i_in,
    input  wire logic                     i_cfg_we,
    input  wire logic [dtq_pkg::LEN_W-1:0] i_cfg_wdata,
    input  wire logic                     i_s1_take,
    output logic                          o_s1_valid,
    output dtq_pkg::t_meta                o_s1_meta,
    output logic      [DESC_WIDTH-1:0]    o_s1_desc
);

    import dtq_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);

    logic             r_s1_valid;
    t_meta            r_s1_meta;
    logic [LEN_W-1:0] r_cap;
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [LEN_W-1:0] r_occ;
    logic [LEN_W-1:0] r_peak;
    logic [DCNT_W-1:0] r_drops;

    logic [PTR_W-1:0] n_head;
    logic [PTR_W-1:0] n_tail;
    logic [LEN_W-1:0] n_occ;
    logic [LEN_W-1:0] n_peak;
    logic [DCNT_W-1:0] n_drops;
    t_meta            n_meta;

    logic             accept;
    logic             is_push;
    logic             can_store;
    logic             do_store;
    logic             do_drop;
    logic             do_pull;
    logic [DESC_WIDTH-1:0] wdata;

    assign o_in_ready = i_rst_n && (!r_s1_valid || i_s1_take);
    assign accept     = i_in_valid && o_in_ready;
    assign is_push    = (t_kind'(i_in.kind) == KIND_PUSH);

    // Effective limit is the smaller of the register and the ring size.
    assign can_store = (r_occ < r_cap) && (32'(r_occ) < 32'(DEPTH));
    assign do_store  = accept && is_push && can_store;
    assign do_drop   = accept && is_push && !can_store;
    assign do_pull   = accept && !is_push && (r_occ != '0);

    generate
        if (DESC_WIDTH >= CDESC_W) begin : g_wide
            assign wdata = DESC_WIDTH'(i_in.descriptor_in);
        end else begin : g_narrow
            assign wdata = i_in.descriptor_in[DESC_WIDTH-1:0];
        end
    endgenerate

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_occ   = r_occ;
        n_peak  = r_peak;
        n_drops = r_drops;
        if (do_store) begin
            n_tail = (r_tail == PTR_W'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
            n_occ  = r_occ + 1'b1;
            if (n_occ > r_peak) begin
                n_peak = n_occ;
            end
        end
        if (do_drop && (r_drops != '1)) begin
            n_drops = r_drops + 1'b1;
        end
        if (do_pull) begin
            n_head = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_occ  = r_occ - 1'b1;
        end
        n_meta.pulled_valid = do_pull;
        n_meta.dropped      = do_drop;
        n_meta.length       = n_occ;
        n_meta.high_water   = n_peak;
        n_meta.drop_count   = n_drops;
    end

    // A pull reads the head slot; its data shows up with the stage-one status.
    dtq_ram #(
        .WIDTH(DESC_WIDTH),
        .DEPTH(DEPTH)
    ) u_slots (
        .i_clk  (i_clk),
        .i_we   (do_store),
        .i_waddr(r_tail),
        .i_wdata(wdata),
        .i_re   (do_pull),
        .i_raddr(r_head),
        .o_rdata(o_s1_desc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_cap      <= CAP_RESET;
            r_head     <= '0;
            r_tail     <= '0;
            r_occ      <= '0;
            r_peak     <= '0;
            r_drops    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (i_s1_take) begin
                r_s1_valid <= 1'b0;
            end
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_occ   <= n_occ;
            r_peak  <= n_peak;
            r_drops <= n_drops;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_meta <= n_meta;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1_meta  = r_s1_meta;

`ifndef NO_ASSERTIONS
    a_no_pull_and_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> !(r_s1_meta.pulled_valid && r_s1_meta.dropped))
        else $error("request reported both a pulled descriptor and a drop");

    a_occ_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_occ) <= 32'(DEPTH)) && (r_peak >= r_occ))
        else $error("occupancy exceeds ring size or high-water mark");

    a_store_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_store |=> r_occ == $past(r_occ) + 1'b1)
        else $error("stored push did not raise occupancy by one");

    a_drops_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_drops >= $past(r_drops))
        else $error("drop counter went backward");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/dtq_outreg.sv -----
`default_nettype none

module dtq_outreg #(
    parameter int unsigned DESC_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s1_valid,
    input  wire dtq_pkg::t_meta        i_s1_meta,
    input  wire logic [DESC_WIDTH-1:0] i_s1_desc,
    output logic                       o_s1_take,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output dtq_pkg::t_out_item         o_out
);

    import dtq_pkg::*;

    logic               r_out_valid;
    t_out_item          r_out;
    t_out_item          n_out;
    logic [CDESC_W-1:0] desc_low;

    generate
        if (DESC_WIDTH >= CDESC_W) begin : g_wide
            assign desc_low = i_s1_desc[CDESC_W-1:0];
        end else begin : g_narrow
            assign desc_low = CDESC_W'(i_s1_desc);
        end
    endgenerate

    assign o_s1_take = i_s1_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        n_out.descriptor_out = i_s1_meta.pulled_valid ? desc_low : '0;
        n_out.pulled_valid   = i_s1_meta.pulled_valid;
        n_out.dropped        = i_s1_meta.dropped;
        n_out.length         = i_s1_meta.length;
        n_out.high_water     = i_s1_meta.high_water;
        n_out.drop_count     = i_s1_meta.drop_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s1_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ----- rtl/core/drop_tail_packet_queue_core.sv -----
// A result passes through the control-stage register and then the output register.
// Throughput: one request per cycle while results are taken; a pull costs one
// read of the descriptor memory and a push one write.
// Reset clears pointers, occupancy, high-water mark and drop count and loads
// the capacity with 1000; the descriptor memory is not cleared and needs no
// clearing pass, so requests are taken as soon as reset is released.
`default_nettype none

module drop_tail_packet_queue_core #(
    parameter int unsigned DEPTH      = 1024,
    parameter int unsigned DESC_WIDTH = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire dtq_pkg::t_in_item         i_in,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output dtq_pkg::t_out_item             o_out,
    input  wire logic                      i_cfg_we,
    input  wire logic [dtq_pkg::LEN_W-1:0] i_cfg_wdata
);

    import dtq_pkg::*;

    logic                  s1_valid;
    logic                  s1_take;
    t_meta                 s1_meta;
    logic [DESC_WIDTH-1:0] s1_desc;

    dtq_ctrl #(
        .DEPTH     (DEPTH),
        .DESC_WIDTH(DESC_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s1_take  (s1_take),
        .o_s1_valid (s1_valid),
        .o_s1_meta  (s1_meta),
        .o_s1_desc  (s1_desc)
    );

    dtq_outreg #(
        .DESC_WIDTH(DESC_WIDTH)
    ) u_outreg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .i_s1_meta  (s1_meta),
        .i_s1_desc  (s1_desc),
        .o_s1_take  (s1_take),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

// ----- test/tb_drop_tail_packet_queue_core.sv -----
`default_nettype none

module tb_drop_tail_packet_queue_core;
    timeunit 1ns;
    timeprecision 1ps;

    import dtq_pkg::*;

    localparam int unsigned QUEUE_DEPTH = 1024;
    localparam int unsigned STALL_LIMIT = 1000;
    localparam logic [LEN_W-1:0] CAP_TOP = 11'h7FF;

    typedef enum logic {
        ROW_CFG = 1'b0,
        ROW_REQ = 1'b1
    } t_row_op;

    typedef struct {
        t_row_op          op;
        logic [LEN_W-1:0] cap;
        t_in_item         req;
        logic             known;
        t_out_item        want;
    } t_row;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    t_in_item         in_req = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out_item        out_res;
    logic             cfg_we = 1'b0;
    logic [LEN_W-1:0] cfg_wdata = '0;

    // Typed-in result that travels with the request currently on the bus.
    logic      req_known = 1'b0;
    t_out_item req_want = '0;

    // Queue model and the results it still owes.
    logic [CDESC_W-1:0] held_desc[$];
    int unsigned        cap_model = int'(CAP_RESET);
    int unsigned        peak_model = 0;
    logic [DCNT_W-1:0]  drops_model = '0;
    t_out_item          owed_res[$];

    t_row        plan[$];
    int unsigned gap_max = 12;
    int unsigned stall_max = 12;
    int unsigned idle_cycles = 0;
    int          errors = 0;
    int unsigned n_req = 0;
    int unsigned n_pull = 0;
    int unsigned n_drop = 0;
    int unsigned n_cfg = 0;
    int unsigned top_len = 0;

    drop_tail_packet_queue_core #(
        .DEPTH      (QUEUE_DEPTH),
        .DESC_WIDTH (CDESC_W)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_res),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic t_out_item queue_step(input t_in_item req);
        t_out_item   res;
        int unsigned limit;
        res = '0;
        limit = (cap_model > QUEUE_DEPTH) ? QUEUE_DEPTH : cap_model;
        if (req.kind == KIND_PUSH) begin
            if (held_desc.size() < limit) begin
                held_desc.push_back(req.descriptor_in);
                if (held_desc.size() > peak_model) begin
                    peak_model = held_desc.size();
                end
            end else begin
                res.dropped = 1'b1;
                if (drops_model != '1) begin
                    drops_model = drops_model + 1'b1;
                end
            end
        end else if (held_desc.size() != 0) begin
            res.descriptor_out = held_desc.pop_front();
            res.pulled_valid = 1'b1;
        end
        res.length = LEN_W'(held_desc.size());
        res.high_water = LEN_W'(peak_model);
        res.drop_count = drops_model;
        return res;
    endfunction

    function automatic void add_cfg(input logic [LEN_W-1:0] cap);
        t_row row;
        row.op = ROW_CFG;
        row.cap = cap;
        row.req = '0;
        row.known = 1'b0;
        row.want = '0;
        plan.push_back(row);
    endfunction

    function automatic void add_req(input t_kind kind, input logic [CDESC_W-1:0] desc,
                                    input logic known = 1'b0, input t_out_item want = '0);
        t_row row;
        row.op = ROW_REQ;
        row.cap = '0;
        row.req.kind = kind;
        row.req.descriptor_in = desc;
        row.known = known;
        row.want = want;
        plan.push_back(row);
    endfunction

    task automatic send_req(input t_in_item req, input logic known, input t_out_item want);
        int unsigned gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req <= req;
        req_known <= known;
        req_want <= want;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Holds the sender off until every owed result has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (owed_res.size() != 0) @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_capacity(input logic [LEN_W-1:0] cap);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= cap;
        @(negedge clk);
        cfg_we <= 1'b0;
        cap_model = int'(cap);
        n_cfg++;
    endtask

    always @(posedge clk) begin : scoreboard
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (owed_res.size() == 0) begin
                $error("result arrived with no request outstanding");
                errors++;
            end else begin
                want = owed_res.pop_front();
                if (out_res.descriptor_out !== want.descriptor_out) begin
                    $error("descriptor_out: expected %h, got %h",
                           want.descriptor_out, out_res.descriptor_out);
                    errors++;
                end
                if (out_res.pulled_valid !== want.pulled_valid) begin
                    $error("pulled_valid: expected %b, got %b",
                           want.pulled_valid, out_res.pulled_valid);
                    errors++;
                end
                if (out_res.dropped !== want.dropped) begin
                    $error("dropped: expected %b, got %b", want.dropped, out_res.dropped);
                    errors++;
                end
                if (out_res.length !== want.length) begin
                    $error("length: expected %0d, got %0d", want.length, out_res.length);
                    errors++;
                end
                if (out_res.high_water !== want.high_water) begin
                    $error("high_water: expected %0d, got %0d",
                           want.high_water, out_res.high_water);
                    errors++;
                end
                if (out_res.drop_count !== want.drop_count) begin
                    $error("drop_count: expected %0d, got %0d",
                           want.drop_count, out_res.drop_count);
                    errors++;
                end
            end
        end
        if (rst_n && in_valid && in_ready) begin
            // The model runs on every request so that its state stays in step
            // with rows whose result is typed in.
            want = queue_step(in_req);
            owed_res.push_back(req_known ? req_want : want);
            n_req++;
            if (want.pulled_valid) n_pull++;
            if (want.dropped) n_drop++;
            if (held_desc.size() > top_len) top_len = held_desc.size();
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $error("no handshake for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : result_sink
        int unsigned stall;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            stall = $urandom_range(0, stall_max);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial begin : stimulus
        t_in_item         req;
        t_out_item        none;
        logic [LEN_W-1:0] cap;
        int unsigned      push_pct;
        none = '0;

        // Fresh queue: empty pull, both descriptor extremes in and out.
        add_req(KIND_PULL, 32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, 1'b0, 11'd0, 11'd0, 32'd0});
        add_req(KIND_PUSH, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, 1'b0, 11'd1, 11'd1, 32'd0});
        add_req(KIND_PUSH, 32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b0, 1'b0, 11'd2, 11'd2, 32'd0});
        add_req(KIND_PULL, 32'h0000_0000, 1'b1, '{32'h0, 1'b1, 1'b0, 11'd1, 11'd2, 32'd0});
        add_req(KIND_PULL, 32'h0000_0000, 1'b1,
                '{32'hFFFF_FFFF, 1'b1, 1'b0, 11'd0, 11'd2, 32'd0});
        add_req(KIND_PULL, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, 1'b0, 11'd0, 11'd2, 32'd0});
        // A capacity of zero drops every push.
        add_cfg(11'd0);
        add_req(KIND_PUSH, 32'h1234_5678, 1'b1, '{32'h0, 1'b0, 1'b1, 11'd0, 11'd2, 32'd1});
        add_req(KIND_PULL, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, 1'b0, 11'd0, 11'd2, 32'd1});
        add_cfg(11'd1);
        add_req(KIND_PUSH, 32'h8000_0001, 1'b1, '{32'h0, 1'b0, 1'b0, 11'd1, 11'd2, 32'd1});
        add_req(KIND_PUSH, 32'h7FFF_FFFE, 1'b1, '{32'h0, 1'b0, 1'b1, 11'd1, 11'd2, 32'd2});
        add_cfg(11'd3);
        add_req(KIND_PUSH, 32'hDEAD_BEEF);
        add_req(KIND_PUSH, 32'h0000_0001);
        // Capacity dropped under the occupancy: drain works, pushes are refused.
        add_cfg(11'd1);
        add_req(KIND_PUSH, 32'hCAFE_F00D);
        add_req(KIND_PULL, 32'h0000_0000);
        add_req(KIND_PUSH, 32'h1357_9BDF);
        add_req(KIND_PULL, 32'hFFFF_FFFF);
        add_req(KIND_PULL, 32'h0000_0000);
        add_req(KIND_PUSH, 32'hA5A5_A5A5);
        add_req(KIND_PULL, 32'h0000_0000);
        add_cfg(CAP_TOP);
        add_req(KIND_PUSH, 32'h5A5A_5A5A);
        add_req(KIND_PUSH, 32'h0F0F_0F0F);
        add_req(KIND_PULL, 32'h0000_0000);
        add_req(KIND_PULL, 32'h0000_0000);
        add_req(KIND_PULL, 32'h0000_0000);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].op == ROW_CFG) begin
                write_capacity(plan[i].cap);
            end else begin
                send_req(plan[i].req, plan[i].known, plan[i].want);
            end
        end

        for (int phase = 0; phase < 6; phase++) begin
            case ($urandom_range(0, 5))
                0: cap = 11'd0;
                1: cap = 11'd1;
                2: cap = LEN_W'($urandom_range(2, 8));
                3: cap = LEN_W'($urandom_range(9, 64));
                4: cap = CAP_RESET;
                default: cap = LEN_W'($urandom_range(1, 2047));
            endcase
            write_capacity(cap);
            case ($urandom_range(0, 2))
                0: gap_max = 0;
                1: gap_max = 3;
                default: gap_max = 12;
            endcase
            case ($urandom_range(0, 2))
                0: stall_max = 0;
                1: stall_max = 3;
                default: stall_max = 12;
            endcase
            push_pct = $urandom_range(35, 70);
            repeat ($urandom_range(20, 50)) begin
                req.kind = ($urandom_range(1, 100) <= push_pct) ? KIND_PUSH : KIND_PULL;
                req.descriptor_in = $urandom;
                if ($urandom_range(0, 39) == 0) drain_results();
                send_req(req, 1'b0, none);
            end
        end

        // Fill to the full depth, check that a capacity above the depth still
        // stops there, then pull the oldest descriptors back out.
        gap_max = 2;
        stall_max = 2;
        write_capacity(11'd1024);
        repeat (QUEUE_DEPTH + 1 - held_desc.size()) begin
            req.kind = KIND_PUSH;
            req.descriptor_in = $urandom;
            send_req(req, 1'b0, none);
        end
        write_capacity(CAP_TOP);
        repeat (2) begin
            req.kind = KIND_PUSH;
            req.descriptor_in = $urandom;
            send_req(req, 1'b0, none);
        end
        repeat (40) begin
            req.kind = KIND_PULL;
            req.descriptor_in = $urandom;
            send_req(req, 1'b0, none);
        end

        drain_results();
        repeat (8) @(negedge clk);

        $display("Run covered %0d requests: %0d descriptors pulled, %0d pushes dropped.",
                 n_req, n_pull, n_drop);
        $display("Queue length reached %0d over %0d capacity settings.", top_len, n_cfg);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire
